[rtl/skd_pkg.sv]
// ----------------------------------------------------------------------------
// skd_pkg
// Shared types and constants of the skeleton and distance labeling block.
// ----------------------------------------------------------------------------
package skd_pkg;

  localparam int unsigned SKD_MAX_WIDTH  = 256;
  localparam int unsigned SKD_MAX_HEIGHT = 256;
  localparam int unsigned MIN_DIM        = 3;

  // commands
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RUN  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // peel modes
  localparam logic [1:0] MODE_SQUARE = 2'd1;
  localparam logic [1:0] MODE_CROSS  = 2'd2;

  // 3x3 window: taps 0..8, the step after the last tap closes the pixel
  localparam logic [3:0] KTAPS = 4'd9;

  typedef enum logic [1:0] {OFF_M, OFF_Z, OFF_P} off_e;

  typedef struct packed {
    logic in_kernel;
    logic in_bounds;
    logic center;
  } nbr_t;

endpackage

[rtl/skd_ram.sv]
// ----------------------------------------------------------------------------
// skd_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module skd_ram #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/skd_nbr.sv]
// ----------------------------------------------------------------------------
// skd_nbr
// Window tap decoder: neighbor address, kernel membership and frame bounds.
// ----------------------------------------------------------------------------
module skd_nbr #(
  parameter int unsigned RW = 8,
  parameter int unsigned CW = 8,
  parameter int unsigned XW = 9
) (
  input  logic [3:0]          k_i,
  input  logic [RW-1:0]       row_i,
  input  logic [CW-1:0]       col_i,
  input  logic [XW-1:0]       width_i,
  input  logic [XW-1:0]       height_i,
  input  logic                square_i,
  output logic [RW-1:0]       nrow_o,
  output logic [CW-1:0]       ncol_o,
  output skd_pkg::nbr_t       flags_o
);
  import skd_pkg::*;

  off_e dr;
  off_e dc;
  logic valid_tap;
  logic row_ok;
  logic col_ok;

  always_comb begin
    valid_tap = 1'b1;
    dr = OFF_Z;
    dc = OFF_Z;
    case (k_i)
      4'd0: begin dr = OFF_M; dc = OFF_M; end
      4'd1: begin dr = OFF_M; dc = OFF_Z; end
      4'd2: begin dr = OFF_M; dc = OFF_P; end
      4'd3: begin dr = OFF_Z; dc = OFF_M; end
      4'd4: begin dr = OFF_Z; dc = OFF_Z; end
      4'd5: begin dr = OFF_Z; dc = OFF_P; end
      4'd6: begin dr = OFF_P; dc = OFF_M; end
      4'd7: begin dr = OFF_P; dc = OFF_Z; end
      4'd8: begin dr = OFF_P; dc = OFF_P; end
      default: valid_tap = 1'b0;
    endcase
  end

  always_comb begin
    row_ok = 1'b1;
    nrow_o = row_i;
    case (dr)
      OFF_M: begin
        row_ok = (row_i != '0);
        nrow_o = row_i - RW'(1);
      end
      OFF_P: begin
        row_ok = (XW'(row_i) != height_i - XW'(1));
        nrow_o = row_i + RW'(1);
      end
      default: ;
    endcase
    col_ok = 1'b1;
    ncol_o = col_i;
    case (dc)
      OFF_M: begin
        col_ok = (col_i != '0);
        ncol_o = col_i - CW'(1);
      end
      OFF_P: begin
        col_ok = (XW'(col_i) != width_i - XW'(1));
        ncol_o = col_i + CW'(1);
      end
      default: ;
    endcase
  end

  // the cross drops the four diagonal taps
  assign flags_o.in_kernel = valid_tap && (square_i || dr == OFF_Z || dc == OFF_Z);
  assign flags_o.in_bounds = row_ok && col_ok;
  assign flags_o.center    = (dr == OFF_Z) && (dc == OFF_Z);

endmodule

[rtl/morphological_skeleton_distance.sv]
// ----------------------------------------------------------------------------
// morphological_skeleton_distance
// Binary frame store with iterative 3x3 peeling into skeleton and distance maps.
// ----------------------------------------------------------------------------
// A load word writes one pixel and gives no result. A read word returns
// both labels of one pixel with the pass count. A run word first sweeps
// the whole map store, all MAX_HEIGHT * 2**clog2(MAX_WIDTH) entries,
// clearing the labels and forcing the ring of the frame to background,
// then peels pass by pass. Each pass scans the active frame twice (erode, then
// dilate and label); every pixel of a scan steps through the window taps one
// at a time through a single memory read port, then takes a closing step.
// The block takes no new word while it works. A result waiting on the output
// holds a read on its last step and a run at the end of its sweep; loads go
// on.
module morphological_skeleton_distance
  import skd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = SKD_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = SKD_MAX_HEIGHT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] row_i,
  input  logic [7:0] col_i,
  input  logic       pixel_on_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] skeleton_level_o,
  output logic [7:0] distance_level_o,
  output logic [7:0] pass_count_o,
  output logic       run_done_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DEPTH = MAX_HEIGHT << CW;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned MW    = (WW > HW) ? WW : HW;
  localparam int unsigned XW    = (MW > 9) ? MW : 9;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_ERODE = 3'd2;
  localparam logic [2:0] S_OPEN  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  logic [2:0] state_q, state_d;

  // configuration
  logic [1:0] mode_q;
  logic [8:0] fw_q, fh_q;
  logic [XW-1:0] fwx, fhx, w, h;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      fw_q   <= 9'd256;
      fh_q   <= 9'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE:   mode_q <= cfg_data_i[1:0];
        REG_WIDTH:  fw_q   <= cfg_data_i;
        REG_HEIGHT: fh_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp the frame size to the legal range
  assign fwx = XW'(fw_q);
  assign fhx = XW'(fh_q);
  assign w = (fwx < XW'(MIN_DIM)) ? XW'(MIN_DIM) :
             (fwx > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : fwx;
  assign h = (fhx < XW'(MIN_DIM)) ? XW'(MIN_DIM) :
             (fhx > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT) : fhx;

  function automatic logic on_ring(input logic [XW-1:0] r, input logic [XW-1:0] c,
                                   input logic [XW-1:0] fw, input logic [XW-1:0] fh);
    on_ring = (r == '0) || (c == '0) || (r == fh - XW'(1)) || (c == fw - XW'(1));
  endfunction

  // sequencer registers
  logic [AW-1:0] clr_q, clr_d;
  logic [RW-1:0] r_q, r_d;
  logic [CW-1:0] c_q, c_d;
  logic [3:0]    k_q, k_d;
  logic          acc_q, acc_d;
  logic          pend_q, pinside_q, pctr_q;
  logic          cen_q, cen_d;
  logic          any_q, any_d;
  logic          sq_q, sq_d;
  logic [7:0]    lvl_q, lvl_d;
  logic [7:0]    pass_cnt_q, pass_cnt_d;
  logic          maps_ok_q, maps_ok_d;
  logic          rd_in_q, rd_in_d;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] skel_out_q, skel_out_d, dist_out_q, dist_out_d;
  logic       run_done_q, run_done_d;

  // window tap decode
  logic [RW-1:0] nrow;
  logic [CW-1:0] ncol;
  nbr_t          nflags;

  skd_nbr #(.RW(RW), .CW(CW), .XW(XW)) u_nbr (
    .k_i      (k_q),
    .row_i    (r_q),
    .col_i    (c_q),
    .width_i  (w),
    .height_i (h),
    .square_i (sq_q),
    .nrow_o   (nrow),
    .ncol_o   (ncol),
    .flags_o  (nflags)
  );

  // memories
  logic          pf_we, pf_wdata, pf_re, pf_rdata;
  logic [AW-1:0] pf_waddr, pf_raddr;
  logic          sc_we, sc_wdata, sc_re, sc_rdata;
  logic          mp_we, mp_re;
  logic          sk_we, dt_we;
  logic [7:0]    sk_wdata, dt_wdata, sk_rdata, dt_rdata;
  logic [AW-1:0] mp_waddr, mp_raddr;

  skd_ram #(.DW(1), .DEPTH(DEPTH)) u_peeled (
    .clk_i, .we_i(pf_we), .waddr_i(pf_waddr), .wdata_i(pf_wdata),
    .re_i(pf_re), .raddr_i(pf_raddr), .rdata_o(pf_rdata)
  );
  skd_ram #(.DW(1), .DEPTH(DEPTH)) u_scratch (
    .clk_i, .we_i(sc_we), .waddr_i({r_q, c_q}), .wdata_i(sc_wdata),
    .re_i(sc_re), .raddr_i({nrow, ncol}), .rdata_o(sc_rdata)
  );
  skd_ram #(.DW(8), .DEPTH(DEPTH)) u_skel (
    .clk_i, .we_i(sk_we), .waddr_i(mp_waddr), .wdata_i(sk_wdata),
    .re_i(mp_re), .raddr_i(mp_raddr), .rdata_o(sk_rdata)
  );
  skd_ram #(.DW(8), .DEPTH(DEPTH)) u_dist (
    .clk_i, .we_i(dt_we), .waddr_i(mp_waddr), .wdata_i(dt_wdata),
    .re_i(mp_re), .raddr_i(mp_raddr), .rdata_o(dt_rdata)
  );

  logic          accept;
  logic          in_frame;
  logic [AW-1:0] in_addr;
  logic [XW-1:0] clr_r, clr_c;
  logic          clr_ring;
  logic          issue;
  logic          acc_next;
  logic          last_px;
  logic          closing;
  logic          open_v;

  // the output register parts the two sides: a waiting result does not block
  // the input, it holds the next result-producing step instead
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_frame   = (XW'(row_i) < h) && (XW'(col_i) < w);
  assign in_addr    = {RW'(row_i), CW'(col_i)};
  assign clr_r      = XW'(clr_q[AW-1:CW]);
  assign clr_c      = XW'(clr_q[CW-1:0]);
  assign clr_ring   = (clr_r < h) && (clr_c < w) && on_ring(clr_r, clr_c, w, h);
  assign issue      = (k_q < KTAPS) && nflags.in_kernel;
  assign closing    = (k_q == KTAPS);
  assign last_px    = (XW'(r_q) == h - XW'(1)) && (XW'(c_q) == w - XW'(1));

  // fold in the tap read last cycle: AND for erosion, OR for dilation
  always_comb begin
    if (k_q == '0) begin
      acc_next = (state_q == S_ERODE);
    end else if (!pend_q) begin
      acc_next = acc_q;
    end else if (state_q == S_ERODE) begin
      acc_next = acc_q & (pinside_q ? pf_rdata : 1'b1);
    end else begin
      acc_next = acc_q | (pinside_q && sc_rdata);
    end
  end

  assign open_v = acc_next;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    r_d         = r_q;
    c_d         = c_q;
    k_d         = k_q;
    acc_d       = acc_q;
    cen_d       = cen_q;
    any_d       = any_q;
    sq_d        = sq_q;
    lvl_d       = lvl_q;
    pass_cnt_d  = pass_cnt_q;
    maps_ok_d   = maps_ok_q;
    rd_in_d     = rd_in_q;
    out_valid_d = out_valid_q && !out_ready_i;
    skel_out_d  = skel_out_q;
    dist_out_d  = dist_out_q;
    run_done_d  = run_done_q;

    pf_we    = 1'b0;
    pf_waddr = {r_q, c_q};
    pf_wdata = 1'b0;
    pf_re    = 1'b0;
    pf_raddr = {nrow, ncol};
    sc_we    = 1'b0;
    sc_wdata = acc_next;
    sc_re    = 1'b0;
    mp_re    = 1'b0;
    mp_raddr = {r_q, c_q};
    mp_waddr = {r_q, c_q};
    sk_we    = 1'b0;
    dt_we    = 1'b0;
    sk_wdata = lvl_q;
    dt_wdata = lvl_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_LOAD: begin
              // drop loads outside the frame, force the ring to background
              pf_we    = in_frame;
              pf_waddr = in_addr;
              pf_wdata = pixel_on_i &&
                         !on_ring(XW'(row_i), XW'(col_i), w, h);
            end
            CMD_RUN: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            CMD_READ: begin
              mp_re    = 1'b1;
              mp_raddr = in_addr;
              rd_in_d  = in_frame && maps_ok_q;
              state_d  = S_READ;
            end
            default: ;
          endcase
        end
      end

      S_READ: begin
        // hold the read data until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          skel_out_d  = rd_in_q ? sk_rdata : 8'd0;
          dist_out_d  = rd_in_q ? dt_rdata : 8'd0;
          run_done_d  = 1'b0;
          state_d     = S_IDLE;
        end
      end

      S_CLEAR: begin
        // wipe both label maps and clear the frame ring
        mp_waddr = clr_q;
        sk_we    = 1'b1;
        dt_we    = 1'b1;
        sk_wdata = 8'd0;
        dt_wdata = 8'd0;
        pf_we    = clr_ring;
        pf_waddr = clr_q;
        pf_wdata = 1'b0;
        clr_d    = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          if (out_valid_q) begin
            // hold on the last entry until the waiting result is taken
            clr_d = clr_q;
          end else begin
            maps_ok_d = 1'b1;
            lvl_d     = 8'd1;
            sq_d      = (mode_q == MODE_SQUARE);
            any_d     = 1'b0;
            r_d       = '0;
            c_d       = '0;
            k_d       = '0;
            state_d   = S_ERODE;
          end
        end
      end

      S_ERODE, S_OPEN: begin
        acc_d = acc_next;
        if (state_q == S_ERODE) begin
          pf_re = issue && nflags.in_bounds;
        end else begin
          sc_re = issue && nflags.in_bounds;
          if (k_q == '0) begin
            // fetch the pixel's own frame bit and labels
            pf_re    = 1'b1;
            pf_raddr = {r_q, c_q};
            mp_re    = 1'b1;
          end
          if (pend_q && pctr_q) begin
            cen_d = sc_rdata;
          end
        end
        k_d = k_q + 4'd1;
        if (closing) begin
          k_d = '0;
          if (state_q == S_ERODE) begin
            sc_we = 1'b1;
          end else begin
            sk_we    = pf_rdata && !open_v && (sk_rdata == 8'd0);
            dt_we    = pf_rdata && !cen_q && (dt_rdata == 8'd0);
            pf_we    = 1'b1;
            pf_wdata = cen_q;
            any_d    = any_q || cen_q;
          end
          if (XW'(c_q) == w - XW'(1)) begin
            c_d = '0;
            r_d = r_q + RW'(1);
          end else begin
            c_d = c_q + CW'(1);
          end
          if (last_px) begin
            r_d = '0;
            c_d = '0;
            if (state_q == S_ERODE) begin
              state_d = S_OPEN;
            end else if (any_q || cen_q) begin
              // advance to the next pass
              any_d   = 1'b0;
              lvl_d   = (lvl_q == 8'hFF) ? lvl_q : lvl_q + 8'd1;
              sq_d    = (mode_q == MODE_SQUARE || mode_q == MODE_CROSS) ? sq_q : !sq_q;
              state_d = S_ERODE;
            end else begin
              pass_cnt_d  = lvl_q;
              out_valid_d = 1'b1;
              skel_out_d  = 8'd0;
              dist_out_d  = 8'd0;
              run_done_d  = 1'b1;
              state_d     = S_IDLE;
            end
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clr_q       <= '0;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      any_q       <= 1'b0;
      sq_q        <= 1'b0;
      lvl_q       <= 8'd0;
      pass_cnt_q  <= 8'd0;
      maps_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      r_q         <= r_d;
      c_q         <= c_d;
      k_q         <= k_d;
      pend_q      <= ((state_q == S_ERODE) || (state_q == S_OPEN)) && issue;
      any_q       <= any_d;
      sq_q        <= sq_d;
      lvl_q       <= lvl_d;
      pass_cnt_q  <= pass_cnt_d;
      maps_ok_q   <= maps_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    pinside_q  <= nflags.in_bounds;
    pctr_q     <= nflags.center;
    cen_q      <= cen_d;
    rd_in_q    <= rd_in_d;
    skel_out_q <= skel_out_d;
    dist_out_q <= dist_out_d;
    run_done_q <= run_done_d;
  end

  assign out_valid_o      = out_valid_q;
  assign skeleton_level_o = skel_out_q;
  assign distance_level_o = dist_out_q;
  assign pass_count_o     = pass_cnt_q;
  assign run_done_o       = run_done_q;

endmodule
